// ----- rtl/jsv_pkg.sv -----
// Package for the JSON syntax validator: scan modes, character classes, literal table.
// No dependencies.
package jsv_pkg;

	localparam int unsigned MaxDepthDefault = 64;

	typedef enum logic [4:0] {
		M_VALUE    = 5'd0,
		M_ARR_ELEM = 5'd1,
		M_OBJ_KEY  = 5'd2,
		M_KEY_STR  = 5'd3,
		M_KEY_ESC  = 5'd4,
		M_COLON    = 5'd5,
		M_STR      = 5'd6,
		M_STR_ESC  = 5'd7,
		M_LIT_T    = 5'd8,
		M_LIT_F    = 5'd9,
		M_LIT_N    = 5'd10,
		M_LIT_END  = 5'd11,
		M_N_MINUS  = 5'd12,
		M_N_ZERO   = 5'd13,
		M_N_INT    = 5'd14,
		M_N_DOT    = 5'd15,
		M_N_FRAC   = 5'd16,
		M_N_E      = 5'd17,
		M_N_ESIGN  = 5'd18,
		M_N_EXP    = 5'd19,
		M_AFTER    = 5'd20
	} mode_t;

	typedef enum logic [1:0] {
		VERDICT_SCAN   = 2'd0,
		VERDICT_ACCEPT = 2'd1,
		VERDICT_REJECT = 2'd2
	} verdict_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       ws;
		logic       digit;
		logic       word;
	} cls_t;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW  = 2;

	// expected byte of literal word w at position p (from 1); 0 at position 0 and past its end
	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] p);
		logic [7:0] r;
		r = 8'h00;
		unique case (w)
			2'd0: begin
				unique case (p)
					3'd1: r = 8'h72;
					3'd2: r = 8'h75;
					3'd3: r = 8'h65;
					default: r = 8'h00;
				endcase
			end
			2'd1: begin
				unique case (p)
					3'd1: r = 8'h61;
					3'd2: r = 8'h6C;
					3'd3: r = 8'h73;
					3'd4: r = 8'h65;
					default: r = 8'h00;
				endcase
			end
			2'd2: begin
				unique case (p)
					3'd1: r = 8'h75;
					3'd2: r = 8'h6C;
					3'd3: r = 8'h6C;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] w);
		return (w == 2'd1) ? 3'd5 : 3'd4;
	endfunction

endpackage

// ----- rtl/jsv_front.sv -----
// Front end: accepts input bytes, classifies them, pushes them into a short queue.
// Depends on jsv_pkg.
module jsv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_ch,
	input  logic              in_last,
	input  logic              pop,
	output logic              q_valid,
	output jsv_pkg::cls_t     q_data
);
	localparam int unsigned CntW = jsv_pkg::QueuePtrW + 1;

	jsv_pkg::cls_t             mem_q [jsv_pkg::QueueDepth];
	logic [jsv_pkg::QueuePtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0]           cnt_q;
	jsv_pkg::cls_t             cls;
	logic                      push;

	always_comb begin
		cls.ch    = in_ch;
		cls.last  = in_last;
		cls.ws    = (in_ch == 8'h20) || (in_ch == 8'h09) || (in_ch == 8'h0A) || (in_ch == 8'h0D);
		cls.digit = (in_ch >= 8'h30) && (in_ch <= 8'h39);
		cls.word  = cls.digit || ((in_ch >= 8'h61) && (in_ch <= 8'h7A))
			|| ((in_ch >= 8'h41) && (in_ch <= 8'h5A)) || (in_ch == 8'h5F);
	end

	assign in_ready = (cnt_q != CntW'(jsv_pkg::QueueDepth));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_data   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CntW'(push) - CntW'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CntW'(jsv_pkg::QueueDepth)) |-> !push)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(jsv_pkg::QueueDepth))
		else $error("queue count out of range");
endmodule

// ----- rtl/jsv_back.sv -----
// Back end: grammar state machine, level stack, counters and output register.
// Depends on jsv_pkg.
module jsv_back #(
	parameter int unsigned MAX_DEPTH = jsv_pkg::MaxDepthDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  jsv_pkg::cls_t     q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        out_verdict,
	output logic              out_final,
	output logic [31:0]       out_fail_pos
);
	localparam int unsigned LvlW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned IdxW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	jsv_pkg::mode_t  mode_q, mode_d;
	logic            stack_q [MAX_DEPTH];
	logic            top_q;
	logic [LvlW-1:0] lvl_q, lvl_d, lvl_nx;
	logic            comma_q, comma_d;
	logic [2:0]      lit_q, lit_d;
	logic [31:0]     cnt_q;
	logic            err_q;
	logic [31:0]     eidx_q;
	logic            fail;
	logic            push_en, push_obj;
	logic            stk_wr;
	logic            top_obj;
	logic [7:0]      c;
	logic            ws, dig, e_ch;
	logic            ov_valid_q;
	logic            take;

	assign take = q_valid && (!ov_valid_q || out_ready);
	assign pop  = take;

	assign c    = q_data.ch;
	assign ws   = q_data.ws;
	assign dig  = q_data.digit;
	assign e_ch = (c == 8'h65) || (c == 8'h45);
	// kind of the innermost open level, kept registered
	assign top_obj = top_q;

	always_comb begin
		logic [1:0] w;
		logic       bv, av, cont;
		mode_d   = mode_q;
		lvl_d    = lvl_q;
		comma_d  = comma_q;
		lit_d    = lit_q;
		fail     = 1'b0;
		push_en  = 1'b0;
		push_obj = (c == 8'h7B);
		bv       = 1'b0;
		av       = 1'b0;
		cont     = 1'b0;
		w        = 2'(mode_q - jsv_pkg::M_LIT_T);
		unique case (mode_q)
			jsv_pkg::M_VALUE: bv = !ws;
			jsv_pkg::M_ARR_ELEM: begin
				if (!ws) begin
					if (c == 8'h5D) begin
						if (comma_q) fail = 1'b1;
						else begin
							lvl_d  = lvl_q - 1'b1;
							mode_d = jsv_pkg::M_AFTER;
						end
					end else begin
						comma_d = 1'b0;
						bv      = 1'b1;
					end
				end
			end
			jsv_pkg::M_OBJ_KEY: begin
				if (!ws) begin
					if (c == 8'h7D) begin
						if (comma_q) fail = 1'b1;
						else begin
							lvl_d  = lvl_q - 1'b1;
							mode_d = jsv_pkg::M_AFTER;
						end
					end else if (c == 8'h22) begin
						comma_d = 1'b0;
						mode_d  = jsv_pkg::M_KEY_STR;
					end else fail = 1'b1;
				end
			end
			jsv_pkg::M_KEY_STR: begin
				if (c == 8'h5C) mode_d = jsv_pkg::M_KEY_ESC;
				else if (c == 8'h22) mode_d = jsv_pkg::M_COLON;
			end
			jsv_pkg::M_KEY_ESC: mode_d = jsv_pkg::M_KEY_STR;
			jsv_pkg::M_COLON: begin
				if (!ws) begin
					if (c == 8'h3A) mode_d = jsv_pkg::M_VALUE;
					else fail = 1'b1;
				end
			end
			jsv_pkg::M_STR: begin
				if (c == 8'h5C) mode_d = jsv_pkg::M_STR_ESC;
				else if (c == 8'h22) mode_d = jsv_pkg::M_AFTER;
			end
			jsv_pkg::M_STR_ESC: mode_d = jsv_pkg::M_STR;
			jsv_pkg::M_LIT_T, jsv_pkg::M_LIT_F, jsv_pkg::M_LIT_N: begin
				if (lit_q >= jsv_pkg::lit_len(w) || c != jsv_pkg::lit_char(w, lit_q)) begin
					fail = 1'b1;
				end else if (lit_q + 3'd1 == jsv_pkg::lit_len(w)) begin
					mode_d = jsv_pkg::M_LIT_END;
					lit_d  = 3'd0;
				end else lit_d = lit_q + 3'd1;
			end
			jsv_pkg::M_LIT_END: begin
				if (q_data.word) fail = 1'b1;
				else av = 1'b1;
			end
			jsv_pkg::M_AFTER: av = 1'b1;
			jsv_pkg::M_N_MINUS: begin
				if (c == 8'h30) mode_d = jsv_pkg::M_N_ZERO;
				else if (dig) mode_d = jsv_pkg::M_N_INT;
				else fail = 1'b1;
			end
			jsv_pkg::M_N_ZERO, jsv_pkg::M_N_INT: begin
				if (mode_q == jsv_pkg::M_N_INT && dig) cont = 1'b1;
				else if (c == 8'h2E) mode_d = jsv_pkg::M_N_DOT;
				else if (e_ch) mode_d = jsv_pkg::M_N_E;
				else av = 1'b1;
			end
			jsv_pkg::M_N_DOT: begin
				if (dig) mode_d = jsv_pkg::M_N_FRAC;
				else fail = 1'b1;
			end
			jsv_pkg::M_N_FRAC: begin
				if (dig) cont = 1'b1;
				else if (e_ch) mode_d = jsv_pkg::M_N_E;
				else av = 1'b1;
			end
			jsv_pkg::M_N_E: begin
				if (c == 8'h2B || c == 8'h2D) mode_d = jsv_pkg::M_N_ESIGN;
				else if (dig) mode_d = jsv_pkg::M_N_EXP;
				else fail = 1'b1;
			end
			jsv_pkg::M_N_ESIGN: begin
				if (dig) mode_d = jsv_pkg::M_N_EXP;
				else fail = 1'b1;
			end
			jsv_pkg::M_N_EXP: begin
				if (dig) cont = 1'b1;
				else av = 1'b1;
			end
			default: fail = 1'b1;
		endcase
		if (bv) begin
			if (lvl_q >= LvlW'(MAX_DEPTH)) fail = 1'b1;
			else if (c == 8'h7B || c == 8'h5B) begin
				push_en = 1'b1;
				lvl_d   = lvl_q + 1'b1;
				comma_d = 1'b0;
				mode_d  = (c == 8'h7B) ? jsv_pkg::M_OBJ_KEY : jsv_pkg::M_ARR_ELEM;
			end else if (c == 8'h22) mode_d = jsv_pkg::M_STR;
			else if (c == 8'h74) begin mode_d = jsv_pkg::M_LIT_T; lit_d = 3'd1; end
			else if (c == 8'h66) begin mode_d = jsv_pkg::M_LIT_F; lit_d = 3'd1; end
			else if (c == 8'h6E) begin mode_d = jsv_pkg::M_LIT_N; lit_d = 3'd1; end
			else if (c == 8'h2D) mode_d = jsv_pkg::M_N_MINUS;
			else if (c == 8'h30) mode_d = jsv_pkg::M_N_ZERO;
			else if (dig) mode_d = jsv_pkg::M_N_INT;
			else fail = 1'b1;
		end
		if (av) begin
			mode_d = jsv_pkg::M_AFTER;
			if (!ws) begin
				if (lvl_q == '0) fail = 1'b1;
				else if (c == 8'h2C) begin
					comma_d = 1'b1;
					mode_d  = top_obj ? jsv_pkg::M_OBJ_KEY : jsv_pkg::M_ARR_ELEM;
				end else if (c == (top_obj ? 8'h7D : 8'h5D)) begin
					lvl_d = lvl_q - 1'b1;
				end else fail = 1'b1;
			end
		end
		if (!cont && fail) begin
			mode_d = mode_q;
		end
		if (q_data.last && !fail) begin
			if (lvl_d != '0) fail = 1'b1;
			else if (!(mode_d == jsv_pkg::M_AFTER || mode_d == jsv_pkg::M_LIT_END
				|| mode_d == jsv_pkg::M_N_ZERO || mode_d == jsv_pkg::M_N_INT
				|| mode_d == jsv_pkg::M_N_FRAC || mode_d == jsv_pkg::M_N_EXP)) fail = 1'b1;
		end
		// level count after this byte, and whether a level is pushed
		stk_wr = !err_q && push_en && !fail;
		if (q_data.last) lvl_nx = '0;
		else if (err_q || fail) lvl_nx = lvl_q;
		else lvl_nx = lvl_d;
	end

	// stack write plus registered read of the new top level
	always_ff @(posedge clk) begin
		if (take) begin
			if (stk_wr) begin
				stack_q[lvl_q[IdxW-1:0]] <= push_obj;
				top_q <= push_obj;
			end else if (lvl_nx != '0) begin
				top_q <= stack_q[IdxW'(lvl_nx - 1'b1)];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= jsv_pkg::M_VALUE;
			lvl_q        <= '0;
			comma_q      <= 1'b0;
			lit_q        <= 3'd0;
			cnt_q        <= '0;
			err_q        <= 1'b0;
			eidx_q       <= '0;
			ov_valid_q   <= 1'b0;
			out_final    <= 1'b0;
			out_verdict  <= jsv_pkg::VERDICT_SCAN;
			out_fail_pos <= '0;
		end else begin
			ov_valid_q <= take || (ov_valid_q && !out_ready);
			if (take) begin
				logic        e_now;
				logic [31:0] ei;
				e_now = err_q || fail;
				ei    = err_q ? eidx_q : cnt_q;
				out_final    <= q_data.last;
				out_verdict  <= e_now ? jsv_pkg::VERDICT_REJECT :
					(q_data.last ? jsv_pkg::VERDICT_ACCEPT : jsv_pkg::VERDICT_SCAN);
				out_fail_pos <= e_now ? ei : 32'd0;
				if (q_data.last) begin
					mode_q  <= jsv_pkg::M_VALUE;
					lvl_q   <= '0;
					comma_q <= 1'b0;
					lit_q   <= 3'd0;
					cnt_q   <= '0;
					err_q   <= 1'b0;
					eidx_q  <= '0;
				end else begin
					if (cnt_q != 32'hFFFF_FFFF) cnt_q <= cnt_q + 32'd1;
					if (!err_q) begin
						if (fail) begin
							err_q  <= 1'b1;
							eidx_q <= cnt_q;
						end else begin
							mode_q  <= mode_d;
							lvl_q   <= lvl_d;
							comma_q <= comma_d;
							lit_q   <= lit_d;
						end
					end
				end
			end
		end
	end

	assign out_valid = ov_valid_q;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_q <= LvlW'(MAX_DEPTH))
		else $error("open level count exceeds depth");
	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && !(take && q_data.last)) |=> (err_q && $stable(eidx_q)))
		else $error("sticky error lost");
	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_fail_pos)))
		else $error("result changed while stalled");
endmodule

// ----- rtl/json_syntax_validator.sv -----
// Top level of the JSON syntax validator: byte stream in, per-byte verdict out.
// Depends on jsv_pkg, jsv_front, jsv_back.
//
//  channel  dir  tdata                                    tlast          tuser
//  s_axis   in   [7:0] text_byte                          last_byte      -
//  m_axis   out  [1:0] verdict, [33:2] fail_position      verdict_final  -
//
// One byte per clock sustained while m_axis_tready stays high; each result takes
// a queue write, then a grammar step into the output register.
// The front classifies bytes into a four-entry queue; the back runs the grammar
// and owns the level stack, so input keeps flowing while a result waits.
// arst_n clears all control state; the stack needs no clearing since a level is
// read only after it was pushed for the current document.
// A stalled m_axis fills the queue, after which s_axis_tready drops.
module json_syntax_validator #(
	parameter int unsigned MAX_DEPTH = jsv_pkg::MaxDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [1:0] verdict, [33:2] fail_position, zero pad
	output logic        m_axis_tlast    // verdict_final
);
	logic              q_valid, pop;
	jsv_pkg::cls_t     q_data;
	logic [1:0]        verdict;
	logic [31:0]       fail_position;

	jsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_ch    (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.pop      (pop),
		.q_valid  (q_valid),
		.q_data   (q_data)
	);

	jsv_back #(.MAX_DEPTH(MAX_DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_verdict  (verdict),
		.out_final    (m_axis_tlast),
		.out_fail_pos (fail_position)
	);

	assign m_axis_tdata = {6'd0, fail_position, verdict};
endmodule

// ----- sim/json_syntax_validator_tb.sv -----
// Testbench for json_syntax_validator: streams directed and random JSON documents,
// predicts the per-byte verdict internally, and checks every output transaction.
// Depends on jsv_pkg and json_syntax_validator.
module json_syntax_validator_tb;

	localparam int unsigned DEPTH      = jsv_pkg::MaxDepthDefault;
	localparam int unsigned STALL_LIMIT = 2000;

	typedef struct {
		jsv_pkg::verdict_t verdict;
		bit                final_flag;
		bit [31:0]         position;
	} verdict_rec_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	json_syntax_validator #(.MAX_DEPTH(DEPTH)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---------------------------------------------------------------------
	// Grammar predictor: its own copy of the scanner state
	// ---------------------------------------------------------------------
	jsv_pkg::mode_t gm_mode;
	bit          gm_is_obj [DEPTH];   // 1 = object level, 0 = array level
	int unsigned gm_levels;
	bit          gm_comma;
	int unsigned gm_lit_pos;
	bit [31:0]   gm_count;
	bit          gm_err;
	bit [31:0]   gm_err_at;
	string       lit_word [3] = '{"true", "false", "null"};

	function automatic bit is_space(byte unsigned c);
		return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic bit is_dig(byte unsigned c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_wordch(byte unsigned c);
		return is_dig(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic void gm_clear();
		gm_mode    = jsv_pkg::M_VALUE;
		gm_levels  = 0;
		gm_comma   = 1'b0;
		gm_lit_pos = 0;
		gm_count   = '0;
		gm_err     = 1'b0;
		gm_err_at  = '0;
	endfunction

	function automatic void gm_fail();
		gm_err    = 1'b1;
		gm_err_at = gm_count;
	endfunction

	function automatic void gm_open_value(byte unsigned c);
		if (gm_levels >= DEPTH) begin
			gm_fail();
		end else if (c == "{" || c == "[") begin
			gm_is_obj[gm_levels] = (c == "{");
			gm_levels++;
			gm_comma = 1'b0;
			gm_mode  = (c == "{") ? jsv_pkg::M_OBJ_KEY : jsv_pkg::M_ARR_ELEM;
		end else if (c == "\"") begin
			gm_mode = jsv_pkg::M_STR;
		end else if (c == "t" || c == "f" || c == "n") begin
			gm_mode    = (c == "t") ? jsv_pkg::M_LIT_T :
				(c == "f") ? jsv_pkg::M_LIT_F : jsv_pkg::M_LIT_N;
			gm_lit_pos = 1;
		end else if (c == "-") begin
			gm_mode = jsv_pkg::M_N_MINUS;
		end else if (c == "0") begin
			gm_mode = jsv_pkg::M_N_ZERO;
		end else if (is_dig(c)) begin
			gm_mode = jsv_pkg::M_N_INT;
		end else begin
			gm_fail();
		end
	endfunction

	// separator or closer after a complete value
	function automatic void gm_after_value(byte unsigned c);
		bit obj;
		if (is_space(c)) return;
		if (gm_levels == 0) begin
			gm_fail();
			return;
		end
		obj = gm_is_obj[gm_levels - 1];
		if (c == ",") begin
			gm_comma = 1'b1;
			gm_mode  = obj ? jsv_pkg::M_OBJ_KEY : jsv_pkg::M_ARR_ELEM;
		end else if (c == (obj ? "}" : "]")) begin
			gm_levels--;
			gm_mode = jsv_pkg::M_AFTER;
		end else begin
			gm_fail();
		end
	endfunction

	function automatic void gm_number(byte unsigned c);
		bit expo;
		bit ended;
		expo  = (c == "e" || c == "E");
		ended = 1'b0;
		case (gm_mode)
			jsv_pkg::M_N_MINUS: begin
				if (c == "0") gm_mode = jsv_pkg::M_N_ZERO;
				else if (is_dig(c)) gm_mode = jsv_pkg::M_N_INT;
				else gm_fail();
			end
			jsv_pkg::M_N_ZERO, jsv_pkg::M_N_INT: begin
				if (gm_mode == jsv_pkg::M_N_INT && is_dig(c)) ;
				else if (c == ".") gm_mode = jsv_pkg::M_N_DOT;
				else if (expo) gm_mode = jsv_pkg::M_N_E;
				else ended = 1'b1;
			end
			jsv_pkg::M_N_DOT: begin
				if (is_dig(c)) gm_mode = jsv_pkg::M_N_FRAC;
				else gm_fail();
			end
			jsv_pkg::M_N_FRAC: begin
				if (is_dig(c)) ;
				else if (expo) gm_mode = jsv_pkg::M_N_E;
				else ended = 1'b1;
			end
			jsv_pkg::M_N_E: begin
				if (c == "+" || c == "-") gm_mode = jsv_pkg::M_N_ESIGN;
				else if (is_dig(c)) gm_mode = jsv_pkg::M_N_EXP;
				else gm_fail();
			end
			jsv_pkg::M_N_ESIGN: begin
				if (is_dig(c)) gm_mode = jsv_pkg::M_N_EXP;
				else gm_fail();
			end
			default: begin
				if (!is_dig(c)) ended = 1'b1;
			end
		endcase
		// the byte that ends a number is also the next token
		if (ended) begin
			gm_mode = jsv_pkg::M_AFTER;
			gm_after_value(c);
		end
	endfunction

	function automatic void gm_scan(byte unsigned c);
		int w;
		case (gm_mode)
			jsv_pkg::M_VALUE: if (!is_space(c)) gm_open_value(c);
			jsv_pkg::M_ARR_ELEM: begin
				if (is_space(c)) ;
				else if (c == "]") begin
					if (gm_comma) gm_fail();
					else begin
						gm_levels--;
						gm_mode = jsv_pkg::M_AFTER;
					end
				end else begin
					gm_comma = 1'b0;
					gm_open_value(c);
				end
			end
			jsv_pkg::M_OBJ_KEY: begin
				if (is_space(c)) ;
				else if (c == "}") begin
					if (gm_comma) gm_fail();
					else begin
						gm_levels--;
						gm_mode = jsv_pkg::M_AFTER;
					end
				end else if (c == "\"") begin
					gm_comma = 1'b0;
					gm_mode  = jsv_pkg::M_KEY_STR;
				end else gm_fail();
			end
			jsv_pkg::M_KEY_STR: begin
				if (c == "\\") gm_mode = jsv_pkg::M_KEY_ESC;
				else if (c == "\"") gm_mode = jsv_pkg::M_COLON;
			end
			jsv_pkg::M_KEY_ESC: gm_mode = jsv_pkg::M_KEY_STR;
			jsv_pkg::M_COLON: begin
				if (is_space(c)) ;
				else if (c == ":") gm_mode = jsv_pkg::M_VALUE;
				else gm_fail();
			end
			jsv_pkg::M_STR: begin
				if (c == "\\") gm_mode = jsv_pkg::M_STR_ESC;
				else if (c == "\"") gm_mode = jsv_pkg::M_AFTER;
			end
			jsv_pkg::M_STR_ESC: gm_mode = jsv_pkg::M_STR;
			jsv_pkg::M_LIT_T, jsv_pkg::M_LIT_F, jsv_pkg::M_LIT_N: begin
				w = (gm_mode == jsv_pkg::M_LIT_T) ? 0 : (gm_mode == jsv_pkg::M_LIT_F) ? 1 : 2;
				if (gm_lit_pos >= lit_word[w].len() || c != lit_word[w][gm_lit_pos]) gm_fail();
				else begin
					gm_lit_pos++;
					if (gm_lit_pos == lit_word[w].len()) begin
						gm_mode    = jsv_pkg::M_LIT_END;
						gm_lit_pos = 0;
					end
				end
			end
			jsv_pkg::M_LIT_END: begin
				if (is_wordch(c)) gm_fail();
				else begin
					gm_mode = jsv_pkg::M_AFTER;
					gm_after_value(c);
				end
			end
			jsv_pkg::M_AFTER: gm_after_value(c);
			default: gm_number(c);
		endcase
	endfunction

	function automatic bit gm_complete();
		if (gm_levels != 0) return 1'b0;
		return gm_mode inside {jsv_pkg::M_AFTER, jsv_pkg::M_LIT_END, jsv_pkg::M_N_ZERO,
			jsv_pkg::M_N_INT, jsv_pkg::M_N_FRAC, jsv_pkg::M_N_EXP};
	endfunction

	function automatic verdict_rec_t gm_step(byte unsigned c, bit last);
		verdict_rec_t r;
		if (!gm_err) begin
			gm_scan(c);
			if (last && !gm_err && !gm_complete()) gm_fail();
		end
		if (gm_count != 32'hFFFF_FFFF) gm_count++;
		r.verdict    = gm_err ? jsv_pkg::VERDICT_REJECT :
			(last ? jsv_pkg::VERDICT_ACCEPT : jsv_pkg::VERDICT_SCAN);
		r.final_flag = last;
		r.position   = gm_err ? gm_err_at : 32'd0;
		if (last) gm_clear();
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Monitors: prediction on input transactions, checking on output ones
	// ---------------------------------------------------------------------
	verdict_rec_t pending_verdicts[$];
	int unsigned  fail_count;
	int unsigned  verdicts_seen;
	int unsigned  accepted_docs, rejected_docs;
	int unsigned  idle_cycles;

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			pending_verdicts.insert(pending_verdicts.size(),
				gm_step(s_axis_tdata, s_axis_tlast));
	end

	always @(posedge clk) begin
		verdict_rec_t exp_v;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			verdicts_seen++;
			if (m_axis_tlast && m_axis_tdata[1:0] == jsv_pkg::VERDICT_ACCEPT) accepted_docs++;
			if (m_axis_tlast && m_axis_tdata[1:0] == jsv_pkg::VERDICT_REJECT) rejected_docs++;
			if (pending_verdicts.size() == 0) begin
				$error("unexpected output transaction, verdict %0d", m_axis_tdata[1:0]);
				fail_count++;
			end else begin
				exp_v = pending_verdicts.pop_front();
				if (m_axis_tdata[1:0] != exp_v.verdict) begin
					$error("verdict: expected %0d, actual %0d", exp_v.verdict, m_axis_tdata[1:0]);
					fail_count++;
				end
				if (m_axis_tlast != exp_v.final_flag) begin
					$error("verdict_final: expected %0d, actual %0d",
						exp_v.final_flag, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tdata[33:2] != exp_v.position) begin
					$error("fail_position: expected %0d, actual %0d",
						exp_v.position, m_axis_tdata[33:2]);
					fail_count++;
				end
				if (m_axis_tdata[39:34] != '0) begin
					$error("pad: expected 0, actual %0h", m_axis_tdata[39:34]);
					fail_count++;
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Receiver: random stall bursts, plus a long hold-off on request
	// ---------------------------------------------------------------------
	bit          calm;          // no idling on either side
	int unsigned sink_hold;     // long hold-off requested by a test
	int unsigned sink_burst;

	always @(negedge clk) begin
		logic rdy;
		if (sink_hold > 0) begin
			sink_hold--;
			rdy = 1'b0;
		end else if (sink_burst > 0) begin
			sink_burst--;
			rdy = 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			sink_burst = $urandom_range(0, 5);
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		m_axis_tready <= rdy;
	end

	// ---------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------
	byte unsigned doc[$];
	int unsigned  bytes_sent;

	function automatic void add_byte(byte unsigned c);
		doc.insert(doc.size(), c);
	endfunction

	task automatic send_byte(byte unsigned c, bit last);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
	endtask

	task automatic send_doc();
		foreach (doc[i]) send_byte(doc[i], i == doc.size() - 1);
		doc.delete();
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
		send_doc();
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		wait (pending_verdicts.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Random document generator
	// ---------------------------------------------------------------------
	function automatic void put_ws();
		byte unsigned sp[4] = '{8'h20, 8'h09, 8'h0A, 8'h0D};
		repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
			add_byte(sp[$urandom_range(0, 3)]);
	endfunction

	function automatic void put_str();
		byte unsigned c;
		add_byte("\"");
		repeat ($urandom_range(0, 5)) begin
			c = byte'($urandom_range(0, 255));
			if (c == "\"") c = "a";
			if (c == "\\") begin
				add_byte(c);
				c = byte'($urandom_range(0, 255));
			end
			add_byte(c);
		end
		add_byte("\"");
	endfunction

	function automatic void put_digits(int n);
		repeat (n) add_byte(byte'("0" + $urandom_range(0, 9)));
	endfunction

	function automatic void put_number();
		if ($urandom_range(0, 1)) add_byte("-");
		if ($urandom_range(0, 3) == 0) add_byte("0");
		else begin
			add_byte(byte'("1" + $urandom_range(0, 8)));
			put_digits($urandom_range(0, 3));
		end
		if ($urandom_range(0, 2) == 0) begin
			add_byte(".");
			put_digits($urandom_range(1, 3));
		end
		if ($urandom_range(0, 2) == 0) begin
			add_byte($urandom_range(0, 1) ? "e" : "E");
			case ($urandom_range(0, 2))
				0: add_byte("+");
				1: add_byte("-");
				default: ;
			endcase
			put_digits($urandom_range(1, 2));
		end
	endfunction

	function automatic void put_value(int lvl);
		int kind;
		string w;
		kind = $urandom_range(0, (lvl < 4) ? 5 : 3);
		put_ws();
		case (kind)
			0: put_str();
			1: put_number();
			2: begin
				w = lit_word[$urandom_range(0, 2)];
				for (int i = 0; i < w.len(); i++) add_byte(w[i]);
			end
			3: put_number();
			4: begin
				add_byte("[");
				for (int i = $urandom_range(0, 3); i > 0; i--) begin
					put_value(lvl + 1);
					if (i > 1) add_byte(",");
				end
				put_ws();
				add_byte("]");
			end
			default: begin
				add_byte("{");
				for (int i = $urandom_range(0, 3); i > 0; i--) begin
					put_ws();
					put_str();
					put_ws();
					add_byte(":");
					put_value(lvl + 1);
					if (i > 1) add_byte(",");
				end
				put_ws();
				add_byte("}");
			end
		endcase
		put_ws();
	endfunction

	// corrupt a well-formed document: flip a byte, cut it short, or insert one
	function automatic void damage_doc();
		int p;
		p = $urandom_range(0, doc.size() - 1);
		case ($urandom_range(0, 2))
			0: doc[p] = byte'($urandom_range(0, 255));
			1: while (doc.size() > p + 1) void'(doc.pop_back());
			default: doc.insert(p, byte'($urandom_range(0, 255)));
		endcase
	endfunction

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------
	task automatic test_scalars();
		send_text("true");
		send_text("false ");
		send_text("null");
		send_text("0");
		send_text("-12.5e+3");
		send_text("\"a\\\"b\"");
	endtask

	task automatic test_containers();
		send_text("[1,{\"k\":[]}]");
		send_text("{\"a\":null,\"b\":{}}");
	endtask

	// trailing comma, truncated literal, word after literal, leading zero,
	// bare dot, whitespace only, non-string key, two top values
	task automatic test_malformed();
		send_text("[1,]");
		send_text("tru");
		send_text("truex");
		send_text("01");
		send_text("1.}");
		send_text("\t");
		send_text("{1:2}");
		send_text("1 2");
		send_text("{\"a\",}");
		send_text("[1]]");
	endtask

	// deepest legal nesting, then one level too deep
	task automatic test_depth_limit();
		repeat (DEPTH) add_byte("[");
		repeat (DEPTH) add_byte("]");
		send_doc();
		repeat (DEPTH + 1) add_byte("[");
		repeat (3) add_byte("]");
		send_doc();
	endtask

	// random bytes of every value, cut into short documents
	task automatic test_noise(int n);
		repeat (n) begin
			repeat ($urandom_range(1, 6)) add_byte(byte'($urandom_range(0, 255)));
			send_doc();
		end
	endtask

	task automatic test_random_docs(int n);
		repeat (n) begin
			put_value(0);
			if ($urandom_range(0, 3) == 0) damage_doc();
			send_doc();
		end
	endtask

	// receiver holds off while the sender keeps offering bytes
	task automatic test_backpressure();
		sink_hold = 200;
		test_random_docs(6);
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		calm          = 1'b0;
		sink_hold     = 0;
		sink_burst    = 0;
		fail_count    = 0;
		verdicts_seen = 0;
		accepted_docs = 0;
		rejected_docs = 0;
		bytes_sent    = 0;
		idle_cycles   = 0;
		gm_clear();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_scalars();
		test_containers();
		test_malformed();
		drain();
		test_depth_limit();
		test_noise(25);
		test_random_docs(12);
		test_backpressure();
		test_random_docs(8);
		calm = 1'b1;
		test_random_docs(5);
		drain();
		repeat (10) @(posedge clk);

		$display("covered %0d bytes and %0d verdicts: scalars, containers, malformed input,",
			bytes_sent, verdicts_seen);
		$display("depth limit, noise, random documents, long hold-off; %0d docs ok, %0d rejected",
			accepted_docs, rejected_docs);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
